>>> src/wtg_pkg.sv
// ----------------------------------------------------------------------------
// wtg_pkg
// Shared types and constants of the waypoint trajectory generator.
// ----------------------------------------------------------------------------
package wtg_pkg;

  // one waypoint table entry
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] arrival;
    logic [31:0] hold;
  } entry_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COUNT      = 3'd0,
    REG_OFF_X      = 3'd1,
    REG_OFF_Y      = 3'd2,
    REG_OFF_Z      = 3'd3,
    REG_START_ALT  = 3'd4,
    REG_END_ALT    = 3'd5,
    REG_CLIMB      = 3'd6,
    REG_RAMP_START = 3'd7
  } reg_e;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // restoring divider: one quotient bit per step
  localparam int DIV_STEPS = 32;
  localparam int DIV_CW    = 5;

  // controller to datapath
  typedef struct packed {
    logic wr_en;
    logic q_start;
    logic scan_adv;
    logic capture;
    logic mul_load;
    logic div_step;
    logic ramp_load;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       hit;
    logic       out_busy;
    logic [4:0] count;
  } sts_t;

endpackage

>>> src/waypoint_trajectory_generator.sv
// ----------------------------------------------------------------------------
// waypoint_trajectory_generator
// Piecewise-linear waypoint trajectory in signed Q16.16 with altitude ramp.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, mode_i, entry_*_i, | sink
//          | query_time_i                              |
//  out     | out_valid_o/out_ready_i, pos_*_o, vel_*_o | source
//  cfg     | cfg_we_i, cfg_addr_i, cfg_data_i          | write only
//
//  A write word is stored on acceptance and the input stays open. A query
//  loads its result after a scan of k entries, one per memory read, the
//  multiply and 32 steps of the shared-divisor restoring divider lanes,
//  whether it interpolates or holds, or after the altitude ramp state with a
//  zero count; the input reopens on the same edge. Reset clears control and
//  configuration; the waypoint memory holds no reset value. A result waits
//  in the output register; a finished query stalls only if it is still full.
// ----------------------------------------------------------------------------
module waypoint_trajectory_generator #(
  parameter int MAX_WAYPOINTS = 16,
  parameter int FRAC_BITS     = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [31:0] entry_x_i,
  input  logic signed [31:0] entry_y_i,
  input  logic signed [31:0] entry_z_i,
  input  logic [31:0]        entry_arrival_i,
  input  logic [31:0]        entry_hold_i,
  input  logic [31:0]        query_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o
);

  localparam int IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

  wtg_pkg::cmd_t cmd;
  wtg_pkg::sts_t sts;
  logic [IW-1:0] rd_addr;

  wtg_ctrl #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS),
    .IW           (IW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .mode_i    (mode_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr)
  );

  wtg_datapath #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS),
    .FRAC_BITS    (FRAC_BITS),
    .IW           (IW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .entry_index_i  (entry_index_i),
    .entry_x_i      (entry_x_i),
    .entry_y_i      (entry_y_i),
    .entry_z_i      (entry_z_i),
    .entry_arrival_i(entry_arrival_i),
    .entry_hold_i   (entry_hold_i),
    .query_time_i   (query_time_i),
    .rd_addr_i      (rd_addr),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .vel_x_o        (vel_x_o),
    .vel_y_o        (vel_y_o),
    .vel_z_o        (vel_z_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

endmodule

>>> src/wtg_ctrl.sv
// ----------------------------------------------------------------------------
// wtg_ctrl
// Sequencer: segment scan, multiply, divide steps, ramp and result load.
// ----------------------------------------------------------------------------
module wtg_ctrl #(
  parameter int MAX_WAYPOINTS = 16,
  parameter int IW            = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  wtg_pkg::sts_t     sts_i,
  output wtg_pkg::cmd_t     cmd_o,
  output logic [IW-1:0]     rd_addr_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MUL, S_DIV, S_RAMP, S_FIN
  } state_e;

  state_e                      state_q;
  logic [IW-1:0]               idx_q;
  logic [wtg_pkg::DIV_CW-1:0]  cnt_q;
  logic                        acc;
  logic                        last;
  logic [31:0]                 ncap;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign ncap       = (32'(sts_i.count) > MAX_WAYPOINTS) ? 32'(MAX_WAYPOINTS)
                                                         : 32'(sts_i.count);
  assign last       = (32'(idx_q) + 32'd1) == ncap;
  assign rd_addr_o  = (state_q == S_SCAN) ? idx_q + IW'(1) : '0;

  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_en     = acc && (mode_i == wtg_pkg::MODE_WRITE);
    cmd_o.q_start   = acc && (mode_i == wtg_pkg::MODE_QUERY);
    cmd_o.scan_adv  = (state_q == S_SCAN) && !sts_i.hit && !last;
    cmd_o.capture   = (state_q == S_SCAN) && (sts_i.hit || last);
    cmd_o.mul_load  = (state_q == S_MUL);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.ramp_load = (state_q == S_RAMP);
    cmd_o.out_load  = (state_q == S_FIN) && !sts_i.out_busy;
  end

  // every capture goes through MUL and DIV; a hold runs the lanes on zero
  // magnitudes with a unit divisor, so its quotients come out zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (cmd_o.q_start) begin
            state_q <= (sts_i.count == '0) ? S_RAMP : S_SCAN;
          end
        end
        S_SCAN: begin
          if (cmd_o.capture) begin
            state_q <= S_MUL;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_MUL: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + wtg_pkg::DIV_CW'(1);
          if (cnt_q == wtg_pkg::DIV_CW'(wtg_pkg::DIV_STEPS - 1)) begin
            state_q <= S_FIN;
          end
        end
        S_RAMP: state_q <= S_FIN;
        S_FIN: begin
          if (cmd_o.out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/wtg_datapath.sv
// ----------------------------------------------------------------------------
// wtg_datapath
// Waypoint memory, configuration, segment search, divider lanes and results.
// ----------------------------------------------------------------------------
module wtg_datapath #(
  parameter int MAX_WAYPOINTS = 16,
  parameter int FRAC_BITS     = 16,
  parameter int IW            = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_addr_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [3:0]          entry_index_i,
  input  logic signed [31:0]  entry_x_i,
  input  logic signed [31:0]  entry_y_i,
  input  logic signed [31:0]  entry_z_i,
  input  logic [31:0]         entry_arrival_i,
  input  logic [31:0]         entry_hold_i,
  input  logic [31:0]         query_time_i,
  input  logic [IW-1:0]       rd_addr_i,
  input  wtg_pkg::cmd_t       cmd_i,
  output wtg_pkg::sts_t       sts_o,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  pos_z_o,
  output logic signed [31:0]  vel_x_o,
  output logic signed [31:0]  vel_y_o,
  output logic signed [31:0]  vel_z_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // configuration
  logic [4:0]  count_q;
  logic [31:0] off_q [3];
  logic [31:0] start_alt_q, end_alt_q, ramp_start_q;
  logic [30:0] climb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      off_q[0]     <= '0;
      off_q[1]     <= '0;
      off_q[2]     <= '0;
      start_alt_q  <= '0;
      end_alt_q    <= '0;
      climb_q      <= '0;
      ramp_start_q <= '0;
    end else if (cfg_we_i) begin
      unique case (wtg_pkg::reg_e'(cfg_addr_i))
        wtg_pkg::REG_COUNT:      count_q      <= cfg_data_i[4:0];
        wtg_pkg::REG_OFF_X:      off_q[0]     <= cfg_data_i;
        wtg_pkg::REG_OFF_Y:      off_q[1]     <= cfg_data_i;
        wtg_pkg::REG_OFF_Z:      off_q[2]     <= cfg_data_i;
        wtg_pkg::REG_START_ALT:  start_alt_q  <= cfg_data_i;
        wtg_pkg::REG_END_ALT:    end_alt_q    <= cfg_data_i;
        wtg_pkg::REG_CLIMB:      climb_q      <= cfg_data_i[30:0];
        wtg_pkg::REG_RAMP_START: ramp_start_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // waypoint memory
  wtg_pkg::entry_t mem [MAX_WAYPOINTS];
  wtg_pkg::entry_t rd_q;
  wtg_pkg::entry_t wr_entry;
  logic            slot_ok;

  assign wr_entry = '{x: entry_x_i, y: entry_y_i, z: entry_z_i,
                      arrival: entry_arrival_i, hold: entry_hold_i};
  assign slot_ok  = 32'(entry_index_i) < MAX_WAYPOINTS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && slot_ok) begin
      mem[IW'(entry_index_i)] <= wr_entry;
    end
    rd_q <= mem[rd_addr_i];
  end

  // segment search
  logic [31:0] t_q;
  logic [32:0] seg_q;
  logic        first_q;
  logic [31:0] prev_q [3];
  logic [31:0] cur [3];
  logic [32:0] arr33, hend;
  logic        early, hit, interp;

  assign cur[0] = rd_q.x;
  assign cur[1] = rd_q.y;
  assign cur[2] = rd_q.z;
  assign arr33  = {1'b0, rd_q.arrival};
  assign hend   = arr33 + {1'b0, rd_q.hold};
  assign early  = {1'b0, t_q} <= arr33;
  assign hit    = early || ({1'b0, t_q} <= hend);
  assign interp = early && !first_q && (arr33 > seg_q);

  // divider lanes: 0..2 position, 3..5 velocity
  logic [31:0] base_q [3];
  logic [31:0] mag_q  [3];
  logic        neg_q  [3];
  logic        ovf_q  [3];
  logic [31:0] rem_q  [6];
  logic [31:0] num_q  [6];
  logic [31:0] dur_q, el_q;

  // ramp
  logic        ramp_q, ract_q, rneg_q;
  logic [31:0] rmag_q;
  logic [62:0] rise_q;

  logic        out_valid_q;
  logic [31:0] res_q [6];

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      t_q     <= query_time_i;
      seg_q   <= '0;
      first_q <= 1'b1;
      ramp_q  <= 1'b0;
    end
    if (cmd_i.scan_adv) begin
      seg_q   <= hend;
      first_q <= 1'b0;
      for (int j = 0; j < 3; j++) prev_q[j] <= cur[j];
    end
    if (cmd_i.capture) begin
      dur_q <= interp ? rd_q.arrival - seg_q[31:0] : 32'd1;
      el_q  <= t_q - seg_q[31:0];
      for (int j = 0; j < 3; j++) begin
        logic signed [32:0] d;
        d = 33'($signed(cur[j])) - 33'($signed(prev_q[j]));
        base_q[j] <= interp ? prev_q[j] : cur[j];
        neg_q[j]  <= interp && d[32];
        mag_q[j]  <= interp ? (d[32] ? 32'(-d) : d[31:0]) : '0;
      end
    end
    if (cmd_i.mul_load) begin
      for (int j = 0; j < 3; j++) begin
        logic [63:0] prod, v;
        prod = 64'(mag_q[j]) * 64'(el_q);
        v    = 64'(mag_q[j]) << FRAC_BITS;
        rem_q[j]   <= prod[63:32];
        num_q[j]   <= prod[31:0];
        rem_q[j+3] <= v[63:32];
        num_q[j+3] <= v[31:0];
        ovf_q[j]   <= (mag_q[j] != '0) && (v[63:32] >= dur_q);
      end
    end
    if (cmd_i.div_step) begin
      for (int k = 0; k < 6; k++) begin
        logic [32:0] r2;
        logic        ge;
        r2 = {rem_q[k], num_q[k][31]};
        ge = r2 >= {1'b0, dur_q};
        rem_q[k] <= ge ? 32'(r2 - {1'b0, dur_q}) : r2[31:0];
        num_q[k] <= {num_q[k][30:0], ge};
      end
    end
    if (cmd_i.ramp_load) begin
      logic signed [32:0] ch;
      ch = 33'($signed(end_alt_q)) - 33'($signed(start_alt_q));
      ramp_q <= 1'b1;
      rneg_q <= ch[32];
      rmag_q <= ch[32] ? 32'(-ch) : ch[31:0];
      rise_q <= 63'(climb_q) * 63'(t_q - ramp_start_q);
      ract_q <= (t_q > ramp_start_q) && (climb_q != '0);
    end
    if (cmd_i.out_load) begin
      if (ramp_q) begin
        logic               ge;
        logic signed [63:0] a0, a1, step, alt;
        ge   = {1'b0, rise_q} >= (64'(rmag_q) << FRAC_BITS);
        a0   = 64'($signed(start_alt_q));
        a1   = 64'($signed(end_alt_q));
        step = $signed(64'(rise_q >> FRAC_BITS));
        if (!ract_q) alt = a0;
        else if (ge) alt = a1;
        else alt = rneg_q ? a0 - step : a0 + step;
        res_q[0] <= off_q[0];
        res_q[1] <= off_q[1];
        res_q[2] <= sat32(alt);
        res_q[3] <= '0;
        res_q[4] <= '0;
        res_q[5] <= (ract_q && !ge) ? (rneg_q ? 32'(-$signed({1'b0, climb_q}))
                                              : {1'b0, climb_q}) : '0;
      end else begin
        for (int j = 0; j < 3; j++) begin
          logic signed [63:0] qp, qv;
          qp = neg_q[j] ? -$signed(64'(num_q[j])) : $signed(64'(num_q[j]));
          qv = neg_q[j] ? -$signed(64'(num_q[j+3])) : $signed(64'(num_q[j+3]));
          res_q[j] <= sat32(64'($signed(base_q[j])) + qp + 64'($signed(off_q[j])));
          if (ovf_q[j]) res_q[j+3] <= neg_q[j] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          else res_q[j+3] <= sat32(qv);
        end
      end
    end
  end

  // hold path runs the divider with zero magnitudes and a unit divisor,
  // so its quotients are zero and no lane overflows

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.hit      = hit;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign sts_o.count    = count_q;

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = res_q[0];
  assign pos_y_o     = res_q[1];
  assign pos_z_o     = res_q[2];
  assign vel_x_o     = res_q[3];
  assign vel_y_o     = res_q[4];
  assign vel_z_o     = res_q[5];

endmodule

>>> src/wtg_checker.sv
// ----------------------------------------------------------------------------
// wtg_checker
// Port-level checks of the trajectory generator, bound to the top level.
// ----------------------------------------------------------------------------
module wtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        mode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] pos_x_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o))
    else $error("stalled result dropped or changed");

  // a write word never makes a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == wtg_pkg::MODE_WRITE) && !out_valid_o
    |=> !out_valid_o)
    else $error("result after write word");

  // an accepted query takes the input ready low in the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == wtg_pkg::MODE_QUERY) |=> !in_ready_o)
    else $error("input taken during query");

  // no result right out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid in reset");

endmodule

bind waypoint_trajectory_generator wtg_checker u_wtg_checker (.*);

>>> sim/wtg_checker.sv
// ----------------------------------------------------------------------------
// wtg_checker
// Watches the config port and both channels of the waypoint trajectory
// generator, predicts every query result and compares it with the output.
// ----------------------------------------------------------------------------
module tb_wtg_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        mode_i,
  input  logic [3:0]  entry_index_i,
  input  logic [31:0] entry_x_i,
  input  logic [31:0] entry_y_i,
  input  logic [31:0] entry_z_i,
  input  logic [31:0] entry_arrival_i,
  input  logic [31:0] entry_hold_i,
  input  logic [31:0] query_time_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [31:0] pos_x_o,
  input  logic [31:0] pos_y_o,
  input  logic [31:0] pos_z_o,
  input  logic [31:0] vel_x_o,
  input  logic [31:0] vel_y_o,
  input  logic [31:0] vel_z_o,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] px, py, pz, vx, vy, vz;
  } traj_t;

  wtg_pkg::entry_t wp_tbl [16];
  logic [4:0]      wp_count;
  logic [31:0]     off_x, off_y, off_z, alt_start, alt_end, ramp_t0;
  logic [30:0]     climb;
  traj_t           traj_q [$];

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint sext(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // signed d * num / den, truncated toward zero
  function automatic longint scale_trunc(longint d, logic [63:0] num, logic [63:0] den);
    logic [127:0] mag, q;
    mag = (d < 0) ? 128'(-d) : 128'(d);
    q = (mag * 128'(num)) / 128'(den);
    return (d < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint coord(wtg_pkg::entry_t e, int j);
    case (j)
      0: return sext(e.x);
      1: return sext(e.y);
      default: return sext(e.z);
    endcase
  endfunction

  function automatic traj_t predict_traj(logic [31:0] t);
    longint      off [3];
    longint      p [3];
    longint      v [3];
    longint      a0, a1, change, d;
    logic [63:0] seg_start, arr, hend, dur, el, mag, rise;
    int          n, hidx, i, j;
    bit          interp, found;
    traj_t       r;
    off[0] = sext(off_x);
    off[1] = sext(off_y);
    off[2] = sext(off_z);
    for (j = 0; j < 3; j++) v[j] = 0;
    if (wp_count != 0) begin
      n = (wp_count > 16) ? 16 : int'(wp_count);
      seg_start = 0;
      hidx = n - 1;
      interp = 0;
      found = 0;
      for (i = 0; i < n && !found; i++) begin
        arr = 64'(wp_tbl[i].arrival);
        hend = arr + 64'(wp_tbl[i].hold);
        if (64'(t) <= arr) begin
          hidx = i;
          if (i > 0 && arr > seg_start) interp = 1;
          found = 1;
        end else if (64'(t) <= hend) begin
          hidx = i;
          found = 1;
        end else begin
          seg_start = hend;
        end
      end
      if (interp) begin
        dur = 64'(wp_tbl[hidx].arrival) - seg_start;
        el = 64'(t) - seg_start;
        for (j = 0; j < 3; j++) begin
          d = coord(wp_tbl[hidx], j) - coord(wp_tbl[hidx - 1], j);
          p[j] = coord(wp_tbl[hidx - 1], j) + scale_trunc(d, el, dur) + off[j];
          v[j] = scale_trunc(d, 64'd65536, dur);
        end
      end else begin
        for (j = 0; j < 3; j++) p[j] = coord(wp_tbl[hidx], j) + off[j];
      end
    end else begin
      a0 = sext(alt_start);
      a1 = sext(alt_end);
      change = a1 - a0;
      mag = (change < 0) ? 64'(-change) : 64'(change);
      p[2] = a0;
      if (t > ramp_t0 && climb != 0) begin
        rise = 64'(climb) * 64'(t - ramp_t0);
        if (rise >= (mag << 16)) begin
          p[2] = a1;
        end else begin
          p[2] = (change >= 0) ? a0 + longint'(rise >> 16) : a0 - longint'(rise >> 16);
          v[2] = (change >= 0) ? longint'(climb) : -longint'(climb);
        end
      end
      p[0] = off[0];
      p[1] = off[1];
    end
    r.px = sat32(p[0]);
    r.py = sat32(p[1]);
    r.pz = sat32(p[2]);
    r.vx = sat32(v[0]);
    r.vy = sat32(v[1]);
    r.vz = sat32(v[2]);
    return r;
  endfunction

  initial begin
    errors_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    traj_t got, want;
    if (!rst_ni) begin
      wp_count = '0;
      {off_x, off_y, off_z, alt_start, alt_end, ramp_t0} = '0;
      climb = '0;
    end else begin
      if (cfg_we_i) begin
        case (wtg_pkg::reg_e'(cfg_addr_i))
          wtg_pkg::REG_COUNT:      wp_count = cfg_data_i[4:0];
          wtg_pkg::REG_OFF_X:      off_x = cfg_data_i;
          wtg_pkg::REG_OFF_Y:      off_y = cfg_data_i;
          wtg_pkg::REG_OFF_Z:      off_z = cfg_data_i;
          wtg_pkg::REG_START_ALT:  alt_start = cfg_data_i;
          wtg_pkg::REG_END_ALT:    alt_end = cfg_data_i;
          wtg_pkg::REG_CLIMB:      climb = cfg_data_i[30:0];
          wtg_pkg::REG_RAMP_START: ramp_t0 = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        if (mode_i == wtg_pkg::MODE_WRITE) begin
          wp_tbl[entry_index_i] = '{entry_x_i, entry_y_i, entry_z_i,
                                    entry_arrival_i, entry_hold_i};
        end else begin
          traj_q = {traj_q, predict_traj(query_time_i)};
        end
      end
      if (out_valid_o && out_ready_i) begin
        got = '{pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o};
        if (traj_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result word %h", got);
          errors_o++;
        end else begin
          want = traj_q.pop_front();
          if (got !== want) begin
            if (errors_o < 10) begin
              $display("mismatch pos exp %h %h %h got %h %h %h",
                       want.px, want.py, want.pz, got.px, got.py, got.pz);
              $display("         vel exp %h %h %h got %h %h %h",
                       want.vx, want.vy, want.vz, got.vx, got.vy, got.vz);
            end
            errors_o++;
          end
        end
      end
    end
    pending_o = traj_q.size();
  end

endmodule

>>> sim/tb_waypoint_trajectory_generator.sv
// ----------------------------------------------------------------------------
// tb_waypoint_trajectory_generator
// Loads waypoint tables and ramp settings, drives write and query words with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_waypoint_trajectory_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = wtg_pkg::MODE_WRITE;
  logic [3:0]  entry_index_i = '0;
  logic [31:0] entry_x_i = '0, entry_y_i = '0, entry_z_i = '0;
  logic [31:0] entry_arrival_i = '0, entry_hold_i = '0, query_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [31:0] pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o;
  int          errors, pending, cycles;
  bit          quiet = 0;
  bit          hold_req = 0;
  logic [31:0] span_end;

  always #2 clk_i = ~clk_i;

  waypoint_trajectory_generator dut (.*);

  tb_wtg_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .mode_i, .entry_index_i,
    .entry_x_i, .entry_y_i, .entry_z_i, .entry_arrival_i, .entry_hold_i,
    .query_time_i, .out_valid_o, .out_ready_i,
    .pos_x_o, .pos_y_o, .pos_z_o, .vel_x_o, .vel_y_o, .vel_z_o,
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (499) @(negedge clk_i);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic send_word(logic m, logic [3:0] idx, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] arr, logic [31:0] hold,
                           logic [31:0] t);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      @(negedge clk_i);
    end
    mode_i = m;
    entry_index_i = idx;
    entry_x_i = x;
    entry_y_i = y;
    entry_z_i = z;
    entry_arrival_i = arr;
    entry_hold_i = hold;
    query_time_i = t;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_entry(logic [3:0] idx, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [31:0] arr, logic [31:0] hold);
    send_word(wtg_pkg::MODE_WRITE, idx, x, y, z, arr, hold, $urandom);
  endtask

  task automatic query(logic [31:0] t);
    send_word(wtg_pkg::MODE_QUERY, 4'($urandom), $urandom, $urandom, $urandom,
              $urandom, $urandom, t);
  endtask

  // drop valid, let every result drain, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic cfg_write(wtg_pkg::reg_e r, logic [31:0] d);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = r;
    cfg_data_i = d;
  endtask

  task automatic cfg_done();
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom;
      default: return 32'($urandom_range(0, 32'h200000)) - 32'h100000;
    endcase
  endfunction

  // well-formed table: non-decreasing arrivals, occasional zero holds and empty segments
  task automatic load_table(int n);
    logic [31:0] cur, hold;
    cur = $urandom_range(0, 32'h40000);
    for (int i = 0; i < n; i++) begin
      hold = ($urandom_range(0, 3) == 0) ? 32'h0 : 32'($urandom_range(0, 32'h20000));
      write_entry(4'(i), pick32(), pick32(), pick32(), cur, hold);
      cur = cur + hold + (($urandom_range(0, 7) == 0) ? 32'h0
                                                      : 32'($urandom_range(1, 32'h80000)));
    end
    span_end = cur;
  endtask

  initial begin
    logic [31:0] a0, a1, rs, mag;
    logic [30:0] cl;
    logic [63:0] horizon;
    bit          ramp;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: saturating segment, short segment, hold end past 32 bits
    write_entry(4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h10000, 32'h8000);
    write_entry(4'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h18001, 32'h0);
    write_entry(4'd2, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h18001, 32'h10000);
    for (int i = 3; i < 15; i++)
      write_entry(4'(i), $urandom, $urandom, $urandom, 32'(32'h30000 * i), 32'h4000);
    write_entry(4'd15, 32'h1234_5678, 32'h0, 32'h8765_4321, 32'hFFFF_0000, 32'hFFFF_FFFF);
    drain();
    cfg_write(wtg_pkg::REG_COUNT, 32'd16);
    cfg_done();
    query(32'h0);
    query(32'h14000);
    query(32'h18001);
    query(32'h20000);
    query(32'h9_4000);
    query(32'hFFFF_FFFF);
    drain();
    cfg_write(wtg_pkg::REG_COUNT, 32'd20);
    cfg_write(wtg_pkg::REG_OFF_X, 32'h7FFF_FFFF);
    cfg_write(wtg_pkg::REG_OFF_Y, 32'h8000_0000);
    cfg_write(wtg_pkg::REG_OFF_Z, 32'hFFFF_FFFF);
    cfg_done();
    query(32'h18001);
    drain();
    cfg_write(wtg_pkg::REG_COUNT, 32'd0);
    cfg_write(wtg_pkg::REG_START_ALT, 32'h8000_0000);
    cfg_write(wtg_pkg::REG_END_ALT, 32'h7FFF_FFFF);
    cfg_write(wtg_pkg::REG_CLIMB, 32'hFFFF_FFFF);
    cfg_write(wtg_pkg::REG_RAMP_START, 32'h100);
    cfg_done();
    query(32'h100);
    query(32'h101);
    query(32'hFFFF_FFFF);
    drain();
    cfg_write(wtg_pkg::REG_CLIMB, 32'h0);
    cfg_done();
    query(32'h5);

    for (int ph = 0; ph < 14; ph++) begin
      drain();
      quiet = (ph >= 12);
      ramp = ($urandom_range(0, 2) == 0);
      a0 = pick32();
      a1 = pick32();
      rs = ($urandom_range(0, 3) == 0) ? pick32() : 32'($urandom_range(0, 32'h100000));
      case ($urandom_range(0, 4))
        0: cl = 31'h7FFF_FFFF;
        1: cl = 31'h0;
        default: cl = 31'($urandom_range(1, 32'h100000));
      endcase
      cfg_write(wtg_pkg::REG_COUNT, ($urandom & 32'hFFFF_FFE0) |
                                    (ramp ? 32'd0 : 32'($urandom_range(1, 31))));
      cfg_write(wtg_pkg::REG_OFF_X, pick32());
      cfg_write(wtg_pkg::REG_OFF_Y, pick32());
      cfg_write(wtg_pkg::REG_OFF_Z, pick32());
      cfg_write(wtg_pkg::REG_START_ALT, a0);
      cfg_write(wtg_pkg::REG_END_ALT, a1);
      cfg_write(wtg_pkg::REG_CLIMB, {1'($urandom), cl});
      cfg_write(wtg_pkg::REG_RAMP_START, rs);
      cfg_done();
      if (ph == 3) hold_req = 1;
      if (ramp) begin
        mag = ($signed(a1) >= $signed(a0)) ? a1 - a0 : a0 - a1;
        horizon = (cl == 0) ? 64'd1000 : ((64'(mag) << 17) / 64'(cl)) + 64'd2;
        if (horizon > 64'hFFFF_FFFF) horizon = 64'hFFFF_FFFF;
        for (int k = 0; k < 100; k++) begin
          if ($urandom_range(0, 9) == 0) query($urandom);
          else query(rs + 32'($urandom_range(0, 32'(horizon))));
        end
      end else begin
        load_table($urandom_range(0, 1) ? 16 : $urandom_range(1, 16));
        for (int k = 0; k < 90; k++) begin
          case ($urandom_range(0, 19))
            0: write_entry(4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
            1, 2: query($urandom);
            default: query($urandom_range(0, span_end + 32'h10000));
          endcase
        end
      end
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> waypoint_trajectory_generator.f
src/wtg_pkg.sv
src/wtg_ctrl.sv
src/wtg_datapath.sv
src/waypoint_trajectory_generator.sv
src/wtg_checker.sv
sim/wtg_checker.sv
sim/tb_waypoint_trajectory_generator.sv
